FILE: sv/bnca_pkg.sv
// Package for the banded nearest-centroid classifier.
// Holds the request and result structs, band table entry type and shared codes.
// No dependencies.
`default_nettype none

package bnca_pkg;

  localparam int unsigned END_W   = 11;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned DIFF_W  = 16;
  localparam int unsigned SQ_W    = 2 * DIFF_W;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_SAMPLE      = 1'b1;

  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_BAND_COUNT    = 1'b1;

  localparam logic [CFG_W-1:0] CLUSTER_COUNT_RESET = 4'd8;
  localparam logic [CFG_W-1:0] BAND_COUNT_RESET    = 4'd8;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef struct packed {
    logic                      operation;
    logic [2:0]                cluster_index;
    logic [2:0]                band_index;
    logic [END_W-1:0]          band_end;
    logic signed [LEVEL_W-1:0] band_level;
    logic signed [LEVEL_W-1:0] sample_value;
    logic                      last_sample;
  } bnca_in_t;

  typedef struct packed {
    logic [3:0]       assigned_cluster;
    logic [ACC_W-1:0] min_distance;
  } bnca_out_t;

  typedef struct packed {
    logic [END_W-1:0]          band_end;
    logic signed [LEVEL_W-1:0] band_level;
  } band_entry_t;

  typedef struct packed {
    logic load_diff;
    logic load_square;
  } sq_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/bnca_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bnca_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/bnca_sqdiff.sv
// Shared subtract-and-square unit: registered magnitude of the difference, then
// its registered square. Depends on bnca_pkg.
`default_nettype none

module bnca_sqdiff
  import bnca_pkg::*;
(
  input  wire logic                      clk,
  input  wire sq_ctrl_t                  ctrl,
  input  wire logic signed [LEVEL_W-1:0] sample,
  input  wire logic signed [LEVEL_W-1:0] level,
  output logic             [SQ_W-1:0]    square
);

  logic signed [LEVEL_W:0] diff;
  logic        [DIFF_W-1:0] mag;
  logic        [DIFF_W-1:0] mag_r;
  logic        [SQ_W-1:0]   square_r;

  always_comb begin
    diff = {sample[LEVEL_W-1], sample} - {level[LEVEL_W-1], level};
    // The magnitude of a 17-bit difference of two 16-bit values fits 16 bits.
    if (diff[LEVEL_W]) begin
      mag = DIFF_W'(-diff);
    end else begin
      mag = DIFF_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_diff) begin
      mag_r <= mag;
    end
    if (ctrl.load_square) begin
      square_r <= mag_r * mag_r;
    end
  end

  assign square = square_r;

endmodule

`default_nettype wire

FILE: sv/banded_nearest_centroid_assign_top.sv
// Banded nearest-centroid classifier: a sample request makes one band table read and one
// shared subtract-square-accumulate pass per cluster in use, plus a table read per band
// advance made for that sample; a closing sample then posts the result once the result
// register can take it. Over a spectrum the band advances total at most the bands in use
// per cluster. A table write is taken in the idle state and leaves the block idle. The band
// table is one RAM with a single read port; band endpoints are found by stepping a
// per-cluster band pointer forward, which is restarted at band 0 after any register
// write, any in-range table write and each posted result.
// Depends on bnca_pkg, bnca_ram and bnca_sqdiff.
`default_nettype none

module banded_nearest_centroid_assign_top
  import bnca_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 8,
  parameter int unsigned MAX_BANDS    = 8,
  parameter int unsigned MAX_FREQS    = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire bnca_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output bnca_out_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned CW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned BW    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int unsigned DEPTH = MAX_CLUSTERS * MAX_BANDS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW    = $clog2(MAX_FREQS + 1);
  localparam int unsigned CMP_W = (FW > END_W) ? FW : END_W;
  localparam int unsigned ENTRY_W = $bits(band_entry_t);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_CHECK  = 6'b000100,
    S_SQUARE = 6'b001000,
    S_ACC    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cluster_count_r, band_count_r;
  logic [COUNT_W-1:0] clusters_used, bands_used;

  logic [CW-1:0] clu_r, clu_nxt;
  logic [BW-1:0] band_r [MAX_CLUSTERS];
  logic [FW-1:0] freq_r;
  logic [ACC_W-1:0] acc_r [MAX_CLUSTERS];
  logic [ACC_W-1:0] best_val_r;
  logic [CW-1:0]    best_idx_r;
  logic signed [LEVEL_W-1:0] sample_r;
  logic last_r;

  logic        out_valid_r;
  bnca_out_t   out_data_r;

  logic        cfg_write;
  logic        in_fire;
  logic        table_write;
  logic        tw_in_range;
  logic [AW-1:0] waddr, raddr;
  band_entry_t wentry, rentry;
  logic [ENTRY_W-1:0] rdata;

  sq_ctrl_t    sq_ctrl;
  logic [SQ_W-1:0] square;

  logic             band_step;
  logic             last_cluster;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_new;
  logic             take_best;
  logic             post_result;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_CLUSTER_COUNT: prdata = APB_DATA_W'(cluster_count_r);
      REG_BAND_COUNT:    prdata = APB_DATA_W'(band_count_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= CLUSTER_COUNT_RESET;
      band_count_r    <= BAND_COUNT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_CLUSTER_COUNT: cluster_count_r <= pwdata[CFG_W-1:0];
        REG_BAND_COUNT:    band_count_r    <= pwdata[CFG_W-1:0];
        default:           cluster_count_r <= cluster_count_r;
      endcase
    end
  end

  // A count of zero acts as one, and a count above the maximum acts as the maximum.
  always_comb begin
    if (cluster_count_r == '0) begin
      clusters_used = COUNT_W'(1);
    end else if (COUNT_W'(cluster_count_r) > COUNT_W'(MAX_CLUSTERS)) begin
      clusters_used = COUNT_W'(MAX_CLUSTERS);
    end else begin
      clusters_used = COUNT_W'(cluster_count_r);
    end
    if (band_count_r == '0) begin
      bands_used = COUNT_W'(1);
    end else if (COUNT_W'(band_count_r) > COUNT_W'(MAX_BANDS)) begin
      bands_used = COUNT_W'(MAX_BANDS);
    end else begin
      bands_used = COUNT_W'(band_count_r);
    end
  end

  // Band table.
  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid & in_ready;
  assign tw_in_range = (32'(in_data.cluster_index) < MAX_CLUSTERS) &&
                       (32'(in_data.band_index) < MAX_BANDS);
  assign table_write = in_fire && (in_data.operation == OP_TABLE_WRITE) && tw_in_range;

  assign waddr = AW'(AW'(in_data.cluster_index) * AW'(MAX_BANDS) + AW'(in_data.band_index));
  assign raddr = AW'(AW'(clu_r) * AW'(MAX_BANDS) + AW'(band_r[clu_r]));
  assign wentry.band_end   = in_data.band_end;
  assign wentry.band_level = in_data.band_level;
  assign rentry = band_entry_t'(rdata);

  bnca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (table_write),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  bnca_sqdiff u_sqdiff (
    .clk    (clk),
    .ctrl   (sq_ctrl),
    .sample (sample_r),
    .level  (rentry.band_level),
    .square (square)
  );

  // The band pointer only moves forward within a spectrum: a band whose endpoint lies
  // below the current frequency stays below it for all later frequencies.
  assign band_step = ((COUNT_W'(band_r[clu_r]) + COUNT_W'(1)) < bands_used) &&
                     (CMP_W'(rentry.band_end) < CMP_W'(freq_r));
  assign last_cluster = (COUNT_W'(clu_r) + COUNT_W'(1)) == clusters_used;

  always_comb begin
    acc_sum = {1'b0, acc_r[clu_r]} + (ACC_W + 1)'(square);
    acc_new = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    take_best = (clu_r == '0) || (acc_new < best_val_r);
  end

  assign post_result = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    clu_nxt   = clu_r;
    sq_ctrl   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.operation == OP_SAMPLE) begin
          state_nxt = S_READ;
          clu_nxt   = '0;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (band_step) begin
          state_nxt = S_READ;
        end else begin
          sq_ctrl.load_diff = 1'b1;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        sq_ctrl.load_square = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (last_cluster) begin
          state_nxt = last_r ? S_DONE : S_IDLE;
        end else begin
          clu_nxt   = clu_r + CW'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (post_result) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clu_r   <= '0;
      freq_r  <= FW'(1);
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        band_r[i] <= '0;
        acc_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clu_r   <= clu_nxt;
      if (cfg_write || table_write) begin
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          band_r[i] <= '0;
        end
      end else if (state_r == S_CHECK && band_step) begin
        band_r[clu_r] <= band_r[clu_r] + BW'(1);
      end else if (post_result) begin
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          band_r[i] <= '0;
        end
      end
      if (state_r == S_ACC) begin
        acc_r[clu_r] <= acc_new;
        if (last_cluster && !last_r && freq_r < FW'(MAX_FREQS)) begin
          freq_r <= freq_r + FW'(1);
        end
      end
      if (post_result) begin
        freq_r <= FW'(1);
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          acc_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_data.sample_value;
      last_r   <= in_data.last_sample;
    end
    if (state_r == S_ACC && take_best) begin
      best_val_r <= acc_new;
      best_idx_r <= clu_r;
    end
  end

  // Result register: a new request may be taken while a result waits here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (post_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_result) begin
      out_data_r.assigned_cluster <= 4'(COUNT_W'(best_idx_r) + COUNT_W'(1));
      out_data_r.min_distance     <= best_val_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
